### rtl/core/mss_pkg.sv
// Shared types, constants and the residue digit table for the minimizer
// super-k-mer splitter. No dependencies.
`default_nettype none

package mss_pkg;

   localparam int RES_W   = 8;
   localparam int CODE_W  = 31;
   localparam int DIGIT_W = 5;
   localparam int RADIX   = 20;

   typedef logic [RES_W-1:0]   residue_type;
   typedef logic [CODE_W-1:0]  code_type;
   typedef logic [DIGIT_W-1:0] digit_type;

   typedef struct packed {
      residue_type residue;
      logic        line_end;
   } req_payload_type;

   typedef struct packed {
      code_type    minimizer_code;
      logic        starts_superkmer;
      residue_type newest_residue;
      logic        is_last;
   } rsp_payload_type;

   typedef struct packed {
      logic take;
      logic load_scan;
      logic scan_step;
      logic enc_step;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic emits;
      logic rsp_free;
   } ctrl_sts_type;

   function automatic digit_type residue_digit(residue_type r);
      digit_type d;
      case (r)
         "G":     d = digit_type'(0);
         "P":     d = digit_type'(1);
         "A":     d = digit_type'(2);
         "V":     d = digit_type'(3);
         "L":     d = digit_type'(4);
         "I":     d = digit_type'(5);
         "M":     d = digit_type'(6);
         "C":     d = digit_type'(7);
         "F":     d = digit_type'(8);
         "Y":     d = digit_type'(9);
         "W":     d = digit_type'(10);
         "H":     d = digit_type'(11);
         "K":     d = digit_type'(12);
         "R":     d = digit_type'(13);
         "Q":     d = digit_type'(14);
         "N":     d = digit_type'(15);
         "E":     d = digit_type'(16);
         "D":     d = digit_type'(17);
         "S":     d = digit_type'(18);
         "T":     d = digit_type'(19);
         default: d = digit_type'(0);
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

### rtl/core/mss_channels_if.sv
// Valid/ready channel interfaces for residue beats and result beats.
// Depends on mss_pkg.
`default_nettype none

interface mss_req_if
   import mss_pkg::*;
   ;
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mss_rsp_if
   import mss_pkg::*;
   ;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/core/minimizer_superkmer_splitter_core.sv
// Minimizer super-k-mer splitter: top level joining sequencer and datapath.
// Flow: an item that completes no window is taken in the idle state, which the core does
// not leave; an item that completes a window (with M = min(MINI_LEN, KMER_LEN)) is followed
// by KMER_LEN - M scan steps, M encode steps and one load into the result register.
// No residue beat is taken until that window is loaded; a result still waiting on the output
// holds the next window in the load step, and input stays blocked until it leaves.
// Reset: synchronous, clears the fill count, line flag, sequencer and result valid.
`default_nettype none

module minimizer_superkmer_splitter_core
   import mss_pkg::*;
#(
   parameter int KMER_LEN = 16,
   parameter int MINI_LEN = 7
) (
   input wire logic   clock,
   input wire logic   reset,
   mss_req_if.sink    req_ch,
   mss_rsp_if.source  rsp_ch
);

   localparam int EFF_MINI = (MINI_LEN < KMER_LEN) ? MINI_LEN : KMER_LEN;
   localparam int CNT_W    = $clog2(KMER_LEN + 1);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   mss_ctrl #(
      .SCAN_STEPS (KMER_LEN - EFF_MINI),
      .ENC_STEPS  (EFF_MINI),
      .CNT_W      (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mss_datapath #(
      .KMER_LEN (KMER_LEN),
      .EFF_MINI (EFF_MINI)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_ch.payload),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_data  (rsp_ch.payload)
   );

endmodule

`default_nettype wire

### rtl/core/mss_ctrl.sv
// Sequencer for the splitter: accept, minimizer scan, base-20 encode, result load.
// Depends on mss_pkg.
`default_nettype none

module mss_ctrl
   import mss_pkg::*;
#(
   parameter int SCAN_STEPS = 9,
   parameter int ENC_STEPS  = 7,
   parameter int CNT_W      = 5
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_ready,
   input  wire ctrl_sts_type sts,
   output      ctrl_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_ENC  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            cmd.take      = req_valid;
            cmd.load_scan = req_valid && sts.emits;
            cnt_in        = '0;
            if (req_valid && sts.emits) begin
               state_in = (SCAN_STEPS == 0) ? ST_ENC : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SCAN_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_ENC;
            end
         end
         ST_ENC: begin
            cmd.enc_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ENC_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/mss_datapath.sv
// Window shift line, minimizer scan register, base-20 encoder and result register.
// Depends on mss_pkg.
`default_nettype none

module mss_datapath
   import mss_pkg::*;
#(
   parameter int KMER_LEN = 16,
   parameter int EFF_MINI = 7
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire req_payload_type req_data,
   input  wire ctrl_cmd_type    cmd,
   output      ctrl_sts_type    sts,
   output      logic            rsp_valid,
   input  wire logic            rsp_ready,
   output      rsp_payload_type rsp_data
);

   localparam int FILL_W = $clog2(KMER_LEN + 1);
   localparam int SUB_W  = EFF_MINI * RES_W;

   residue_type       window_ff [KMER_LEN];
   residue_type       window_in [KMER_LEN];
   residue_type       scan_ff   [KMER_LEN+1];
   logic [FILL_W-1:0] fill_ff;
   logic              seen_ff;
   logic              first_ff;
   logic              last_ff;
   residue_type       newest_ff;
   logic [SUB_W-1:0]  best_ff;
   logic [SUB_W-1:0]  start_sub;
   logic [SUB_W-1:0]  cand_sub;
   code_type          code_ff;
   code_type          code_in;
   code_type          prev_ff;
   logic              rsp_valid_ff;
   rsp_payload_type   rsp_data_ff;

   always_comb begin
      for (int i = 0; i < KMER_LEN - 1; i++) begin
         window_in[i] = window_ff[i+1];
      end
      window_in[KMER_LEN-1] = req_data.residue;
      for (int k = 0; k < EFF_MINI; k++) begin
         start_sub[(EFF_MINI-1-k)*RES_W +: RES_W] = window_in[k];
         cand_sub[(EFF_MINI-1-k)*RES_W +: RES_W]  = scan_ff[k+1];
      end
      code_in = code_ff * code_type'(RADIX)
              + code_type'(residue_digit(best_ff[SUB_W-1 -: RES_W]));
   end

   assign sts.emits    = (fill_ff == FILL_W'(KMER_LEN)) || (fill_ff == FILL_W'(KMER_LEN - 1));
   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         seen_ff <= 1'b0;
      end else if (cmd.take) begin
         if (req_data.line_end) begin
            fill_ff <= '0;
            seen_ff <= 1'b0;
         end else begin
            if (fill_ff != FILL_W'(KMER_LEN)) begin
               fill_ff <= fill_ff + 1'b1;
            end
            if (sts.emits) begin
               seen_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         window_ff <= window_in;
      end
      if (cmd.load_scan) begin
         for (int i = 0; i < KMER_LEN; i++) begin
            scan_ff[i] <= window_in[i];
         end
         scan_ff[KMER_LEN] <= '0;
         best_ff   <= start_sub;
         code_ff   <= '0;
         first_ff  <= !seen_ff;
         last_ff   <= req_data.line_end;
         newest_ff <= req_data.residue;
      end else if (cmd.scan_step) begin
         for (int i = 0; i < KMER_LEN; i++) begin
            scan_ff[i] <= scan_ff[i+1];
         end
         if (cand_sub < best_ff) begin
            best_ff <= cand_sub;
         end
      end else if (cmd.enc_step) begin
         code_ff <= code_in;
         best_ff <= best_ff << RES_W;
      end
      if (cmd.load_rsp) begin
         prev_ff                      <= code_ff;
         rsp_data_ff.minimizer_code   <= code_ff;
         rsp_data_ff.starts_superkmer <= first_ff || (code_ff != prev_ff);
         rsp_data_ff.newest_residue   <= newest_ff;
         rsp_data_ff.is_last          <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

endmodule

`default_nettype wire

### rtl/core/mss_checker.sv
// Port-level checks for the splitter core and the bind that attaches them.
// Depends on mss_pkg and minimizer_superkmer_splitter_core.
`default_nettype none

module mss_checker
   import mss_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_ready,
   input wire logic            rsp_valid,
   input wire logic            rsp_ready,
   input wire rsp_payload_type rsp_data
);

   logic prev_last_ff;
   logic got_req_ff;
   logic prev_valid_ff;
   logic prev_ready_ff;
   logic fresh;

   assign fresh = rsp_valid && (!prev_valid_ff || prev_ready_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_valid_ff <= 1'b0;
         prev_ready_ff <= 1'b0;
      end else begin
         prev_valid_ff <= rsp_valid;
         prev_ready_ff <= rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_last_ff <= 1'b1;
         got_req_ff   <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            prev_last_ff <= rsp_data.is_last;
         end
         if (req_valid && req_ready) begin
            got_req_ff <= 1'b1;
         end else if (fresh) begin
            got_req_ff <= 1'b0;
         end
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_line_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && prev_last_ff |-> rsp_data.starts_superkmer)
      else $error("first result of a line does not start a super-k-mer");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      fresh |-> got_req_ff)
      else $error("result beat without a residue beat behind it");

endmodule

bind minimizer_superkmer_splitter_core mss_checker u_mss_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.payload)
);

`default_nettype wire
